/* hw/rtl/sts_pkg.sv */
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and constants for the sorted table binary search block.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int TABLE_DEPTH   = 1024;
    localparam int ELEMENT_WIDTH = 32;
    localparam int ADDR_W        = $clog2(TABLE_DEPTH);
    localparam int COUNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W         = 10;
    localparam int POS_W         = 10;
    localparam int DATA_W        = 32;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef struct packed {
        logic                     req_type;
        logic [IDX_W-1:0]         entry_index;
        logic signed [DATA_W-1:0] data_value;
    } t_req;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] match_position;
    } t_rsp;

    typedef struct packed {
        logic                            we;
        logic [ADDR_W-1:0]               waddr;
        logic signed [ELEMENT_WIDTH-1:0] wdata;
        logic [ADDR_W-1:0]               raddr;
    } t_ram_req;

endpackage

/* hw/rtl/sts_ram.sv */
// ----------------------------------------------------------------------------
// sts_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/sts_search.sv */
// ----------------------------------------------------------------------------
// sts_search
// Sequencer for table loads and the halving search, one compare per cycle.
// ----------------------------------------------------------------------------
module sts_search
    import sts_pkg::*;
(
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  t_req                            i_req,
    input  logic [COUNT_W-1:0]              i_elem_count,
    input  logic signed [ELEMENT_WIDTH-1:0] i_rd_data,
    output logic                            o_busy,
    output t_ram_req                        o_ram,
    output logic                            o_done,
    output t_rsp                            o_rsp
);

    typedef enum logic {
        S_IDLE,
        S_CMP
    } t_state;

    t_state                          r_state, n_state;
    logic [COUNT_W-1:0]              r_low, n_low;
    logic [COUNT_W-1:0]              r_high, n_high;
    logic [ADDR_W-1:0]               r_mid, n_mid;
    logic signed [ELEMENT_WIDTH-1:0] r_key;

    logic [COUNT_W-1:0] eff_count;
    logic [COUNT_W-1:0] first_high;
    logic [COUNT_W:0]   range_sum;
    logic [COUNT_W-1:0] mid_up;
    logic [COUNT_W-1:0] mid_dn;
    logic               is_search;

    assign eff_count  = (32'(i_elem_count) > TABLE_DEPTH) ? COUNT_W'(TABLE_DEPTH)
                                                          : i_elem_count;
    assign first_high = eff_count - COUNT_W'(1);
    assign mid_up     = COUNT_W'(r_mid) + COUNT_W'(1);
    assign mid_dn     = COUNT_W'(r_mid) - COUNT_W'(1);
    assign is_search  = (i_req.req_type == REQ_SEARCH);

    always_comb begin
        n_state   = r_state;
        n_low     = r_low;
        n_high    = r_high;
        n_mid     = r_mid;
        o_done    = 1'b0;
        o_rsp     = '0;
        o_ram.we    = 1'b0;
        o_ram.waddr = i_req.entry_index[ADDR_W-1:0];
        o_ram.wdata = ELEMENT_WIDTH'(i_req.data_value);
        range_sum   = '0;

        case (r_state)
            S_IDLE: begin
                n_low  = '0;
                n_high = first_high;
                n_mid  = ADDR_W'(first_high >> 1);
                if (i_start) begin
                    if (!is_search) begin
                        o_ram.we = (32'(i_req.entry_index) < TABLE_DEPTH);
                    end else if (eff_count == '0) begin
                        o_done = 1'b1;
                    end else begin
                        n_state = S_CMP;
                    end
                end
            end
            S_CMP: begin
                if (i_rd_data == r_key) begin
                    o_done             = 1'b1;
                    o_rsp.found        = 1'b1;
                    o_rsp.match_position = POS_W'(r_mid);
                    n_state            = S_IDLE;
                end else if (i_rd_data < r_key) begin
                    n_low = mid_up;
                    if (mid_up > r_high) begin
                        o_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_high = mid_dn;
                    if ((r_mid == '0) || (r_low > mid_dn)) begin
                        o_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
                range_sum = (COUNT_W + 1)'(n_low) + (COUNT_W + 1)'(n_high);
                n_mid     = ADDR_W'(range_sum >> 1);
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        o_ram.raddr = n_mid;
    end

    assign o_busy      = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_low  <= n_low;
        r_high <= n_high;
        r_mid  <= n_mid;
        if (i_start) begin
            r_key <= ELEMENT_WIDTH'(i_req.data_value);
        end
    end

endmodule

/* hw/rtl/sorted_table_binary_search.sv */
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Table of ascending signed values with load and binary search transactions.
// ----------------------------------------------------------------------------
//  Channel  | Ports                                  | Carries
//  ---------+----------------------------------------+-----------------------
//  request  | i_in_valid, o_in_stall, i_in_data      | load or search (t_req)
//  result   | o_out_valid, i_out_stall, o_out_data   | found, position (t_rsp)
//  config   | i_cfg_wr_en, i_cfg_wr_data             | element_count
//
//  A search runs as a series of halving steps; each step is one RAM read
//  and one compare of the shared unit.
//  Synchronous reset clears the sequencer state, the output valid flag and the count;
//  table contents are not cleared. A new transaction is taken once the
//  sequencer is idle and the output register is free or drains in that cycle.
// ----------------------------------------------------------------------------
module sorted_table_binary_search
    import sts_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_req               i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_rsp               o_out_data,
    input  logic               i_cfg_wr_en,
    input  logic [COUNT_W-1:0] i_cfg_wr_data
);

    logic [COUNT_W-1:0] r_elem_count;
    logic               r_out_valid;
    t_rsp               r_out_data;

    logic                            start;
    logic                            busy;
    logic                            done;
    t_rsp                            rsp;
    t_ram_req                        ram_req;
    logic signed [ELEMENT_WIDTH-1:0] rd_data;

    assign o_in_stall = busy || (r_out_valid && i_out_stall);
    assign start      = i_in_valid && !o_in_stall;

    sts_search u_search (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_req        (i_in_data),
        .i_elem_count (r_elem_count),
        .i_rd_data    (rd_data),
        .o_busy       (busy),
        .o_ram        (ram_req),
        .o_done       (done),
        .o_rsp        (rsp)
    );

    sts_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_elem_count <= i_cfg_wr_data;
            end
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (done) begin
            r_out_data <= rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
